// File: sv/swrl_pkg.sv
`timescale 1ns / 1ps

package swrl_pkg;

    // Field widths of the event and result transactions.
    localparam int SRC_W        = 16;
    localparam int TS_W         = 32;
    localparam int INTERVAL_W   = 20;
    localparam int MATCH_OUT_W  = 3;

    // Packed stream widths, padded to whole bytes.
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 8;

    // Bit positions inside the stream words.
    localparam int IN_SRC_LSB   = 0;
    localparam int IN_TS_LSB    = SRC_W;
    localparam int OUT_ALLOW_BIT = 0;
    localparam int OUT_MATCH_LSB = 1;

    // Reset value of the minimum interval register.
    localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RESET = INTERVAL_W'(100000);

    typedef logic [SRC_W-1:0]      source_t;
    typedef logic [TS_W-1:0]       stamp_t;
    typedef logic [INTERVAL_W-1:0] interval_t;

endpackage

// File: sv/swrl_window.sv
`timescale 1ns / 1ps

module swrl_window #(
    parameter int WINDOW_ENTRIES = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  swrl_pkg::source_t wr_source,
    input  swrl_pkg::stamp_t  wr_time,
    output swrl_pkg::source_t entry_source [WINDOW_ENTRIES],
    output swrl_pkg::stamp_t  entry_time   [WINDOW_ENTRIES],
    output logic [WINDOW_ENTRIES-1:0] entry_valid
);
    import swrl_pkg::*;

    localparam int PTR_W = (WINDOW_ENTRIES > 1) ? $clog2(WINDOW_ENTRIES) : 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WINDOW_ENTRIES - 1);

    logic [PTR_W-1:0]          write_ptr_reg;
    logic [PTR_W-1:0]          write_ptr_next;
    logic [WINDOW_ENTRIES-1:0] entry_valid_reg;
    logic [WINDOW_ENTRIES-1:0] entry_valid_next;
    source_t                   entry_source_reg [WINDOW_ENTRIES];
    stamp_t                    entry_time_reg   [WINDOW_ENTRIES];

    // The pointer walks the ring and wraps after the last slot.
    always_comb
    begin
        write_ptr_next   = write_ptr_reg;
        entry_valid_next = entry_valid_reg;
        if (wr_en)
        begin
            write_ptr_next = (write_ptr_reg == LAST_SLOT) ? '0 : write_ptr_reg + 1'b1;
            entry_valid_next[write_ptr_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_ptr_reg   <= '0;
            entry_valid_reg <= '0;
        end
        else
        begin
            write_ptr_reg   <= write_ptr_next;
            entry_valid_reg <= entry_valid_next;
        end
    end

    // The new event overwrites the oldest slot; invalid slots are never matched.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_source_reg[write_ptr_reg] <= wr_source;
            entry_time_reg[write_ptr_reg]   <= wr_time;
        end
    end

    assign entry_source = entry_source_reg;
    assign entry_time   = entry_time_reg;
    assign entry_valid  = entry_valid_reg;

endmodule

// File: sv/swrl_match.sv
`timescale 1ns / 1ps

module swrl_match #(
    parameter int WINDOW_ENTRIES = 6
) (
    input  swrl_pkg::source_t   source_id,
    input  swrl_pkg::stamp_t    timestamp,
    input  swrl_pkg::interval_t min_interval,
    input  swrl_pkg::source_t   entry_source [WINDOW_ENTRIES],
    input  swrl_pkg::stamp_t    entry_time   [WINDOW_ENTRIES],
    input  logic [WINDOW_ENTRIES-1:0] entry_valid,
    output logic                allowed,
    output logic [swrl_pkg::MATCH_OUT_W-1:0] match_count
);
    import swrl_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW_ENTRIES + 1);
    localparam int PROD_W = CNT_W + INTERVAL_W;
    localparam int CMP_W  = CNT_W + TS_W;

    logic [WINDOW_ENTRIES-1:0] hit;
    stamp_t                    age [WINDOW_ENTRIES];
    logic [CNT_W-1:0]          count;
    stamp_t                    oldest_age;
    logic [PROD_W-1:0]         budget;
    logic [CNT_W+MATCH_OUT_W-1:0] count_ext;

    // Per-slot compare and wrapped age against the current time.
    always_comb
    begin
        for (int i = 0; i < WINDOW_ENTRIES; i++)
        begin
            hit[i] = entry_valid[i] && (entry_source[i] == source_id);
            age[i] = timestamp - entry_time[i];
        end
    end

    // Count the matching slots and keep the largest age among them.
    always_comb
    begin
        count      = '0;
        oldest_age = '0;
        for (int i = 0; i < WINDOW_ENTRIES; i++)
        begin
            if (hit[i])
            begin
                count = count + 1'b1;
                if (age[i] > oldest_age)
                begin
                    oldest_age = age[i];
                end
            end
        end
    end

    // Deny when (count - 1) intervals do not fit into the span of the window.
    always_comb
    begin
        budget  = PROD_W'(count - 1'b1) * PROD_W'(min_interval);
        allowed = (count <= CNT_W'(1)) ||
                  !(CMP_W'(budget) > CMP_W'(oldest_age));
    end

    assign count_ext   = {{MATCH_OUT_W{1'b0}}, count};
    assign match_count = count_ext[MATCH_OUT_W-1:0];

endmodule

// File: sv/sliding_window_rate_limiter.sv
`timescale 1ns / 1ps

// Per-source event flood limiter. Each event transaction carries a source id
// and a timestamp; the block stores it in a ring of the last WINDOW_ENTRIES
// events, overwriting the oldest, then counts the stored events of the same
// source (this one included) and takes the oldest of their timestamps. With
// one match the event is allowed; otherwise it is denied when (count - 1) times
// min_interval exceeds the wrapped age of the oldest match. One result follows
// each event. A new event is accepted in every cycle unless the output stalls:
// the ring is updated at the accepting edge, and the compare over all slots,
// the multiply and the decision sit between the event register and the result
// register. The window is empty after reset. The user must write min_interval
// via cfg_wen/cfg_wdata while no event is in flight; the block does not check.

module sliding_window_rate_limiter #(
    parameter int WINDOW_ENTRIES = 6
) (
    input  logic clk,
    input  logic rst_n,

    // Configuration.
    input  logic                            cfg_wen,
    input  logic [swrl_pkg::INTERVAL_W-1:0] cfg_wdata,   // min_interval

    // Event stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [swrl_pkg::IN_TDATA_W-1:0] s_axis_tdata, // source_id[15:0], timestamp[47:16]

    // Result stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [swrl_pkg::OUT_TDATA_W-1:0] m_axis_tdata // allowed[0], match_count[3:1], zero[7:4]
);
    import swrl_pkg::*;

    interval_t min_interval_reg;
    logic      stage_valid_reg;
    source_t   stage_source_reg;
    stamp_t    stage_time_reg;
    logic      out_valid_reg;
    logic      out_allowed_reg;
    logic [MATCH_OUT_W-1:0] out_match_reg;

    logic      in_fire;
    logic      stage_adv;
    source_t   in_source;
    stamp_t    in_time;
    source_t   entry_source [WINDOW_ENTRIES];
    stamp_t    entry_time   [WINDOW_ENTRIES];
    logic [WINDOW_ENTRIES-1:0] entry_valid;
    logic      allowed_next;
    logic [MATCH_OUT_W-1:0] match_next;

    // Handshake: the event stage moves on whenever the result register is empty or being read out.
    assign stage_adv     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !stage_valid_reg || stage_adv;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign in_source = s_axis_tdata[IN_SRC_LSB +: SRC_W];
    assign in_time   = s_axis_tdata[IN_TS_LSB +: TS_W];

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= MIN_INTERVAL_RESET;
        end
        else if (cfg_wen)
        begin
            min_interval_reg <= cfg_wdata;
        end
    end

    // Ring of recent events, written at the accepting edge.
    swrl_window #(
        .WINDOW_ENTRIES (WINDOW_ENTRIES)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (in_fire),
        .wr_source    (in_source),
        .wr_time      (in_time),
        .entry_source (entry_source),
        .entry_time   (entry_time),
        .entry_valid  (entry_valid)
    );

    // Event register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            stage_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_source_reg <= in_source;
            stage_time_reg   <= in_time;
        end
    end

    // Window match and rate decision for the registered event.
    swrl_match #(
        .WINDOW_ENTRIES (WINDOW_ENTRIES)
    ) u_match (
        .source_id    (stage_source_reg),
        .timestamp    (stage_time_reg),
        .min_interval (min_interval_reg),
        .entry_source (entry_source),
        .entry_time   (entry_time),
        .entry_valid  (entry_valid),
        .allowed      (allowed_next),
        .match_count  (match_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_adv)
        begin
            out_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_adv && stage_valid_reg)
        begin
            out_allowed_reg <= allowed_next;
            out_match_reg   <= match_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - MATCH_OUT_W - 1){1'b0}},
                            out_match_reg, out_allowed_reg};

endmodule
